FILE: design/mcp_pkg.sv
// shared types, codes and sizes for the midi channel message parser
`timescale 1ns / 1ps

package mcp_pkg;

    // queue depth defaults
    localparam int EVENT_SLOTS_DEF = 16;
    localparam int OPQ_DEPTH       = 2;
    localparam int OPQ_PTR_W       = $clog2(OPQ_DEPTH);

    // port widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 3;

    // event kinds
    localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_CONTROL  = 2'd2;

    // item commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // status groups (upper nibble of a status byte)
    localparam logic [3:0] GRP_NOTE_OFF = 4'h8;
    localparam logic [3:0] GRP_NOTE_ON  = 4'h9;
    localparam logic [3:0] GRP_CONTROL  = 4'hB;
    localparam logic [3:0] GRP_PROGRAM  = 4'hC;
    localparam logic [3:0] GRP_PRESSURE = 4'hD;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] key;
        logic [6:0] vel;
    } event_t;

    // classified word handed from the parser to the queue engine
    typedef struct packed {
        logic   is_pop;
        logic   push;
        event_t ev;
    } op_t;

endpackage

FILE: design/mcp_front.sv
// parser front end: tracks status and data bytes and classifies each word
`timescale 1ns / 1ps

module mcp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [7:0]           byte_in,
    output logic                 op_valid,
    input  logic                 op_ready,
    output mcp_pkg::op_t         op
);
    import mcp_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DATA1 = 2'd1;
    localparam logic [1:0] PH_DATA2 = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] status_reg, status_next;
    logic [6:0] first_reg, first_next;
    logic       accept;
    logic [3:0] grp;
    logic       push;
    logic [1:0] kind;

    assign accept   = in_valid && in_ready;
    assign in_ready = op_ready;
    assign op_valid = in_valid;
    assign grp      = status_reg[7:4];

    always_comb
    begin
        phase_next  = phase_reg;
        status_next = status_reg;
        first_next  = first_reg;
        push        = 1'b0;
        kind        = KIND_NOTE_OFF;
        if (cmd == CMD_BYTE)
        begin
            if (byte_in[7])
            begin
                status_next = byte_in;
                phase_next  = PH_DATA1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_DATA1:
                    begin
                        first_next = byte_in[6:0];
                        phase_next = (grp == GRP_PROGRAM || grp == GRP_PRESSURE) ?
                                     PH_IDLE : PH_DATA2;
                    end
                    PH_DATA2:
                    begin
                        phase_next = PH_IDLE;
                        priority if (grp == GRP_NOTE_ON)
                        begin
                            push = 1'b1;
                            kind = (byte_in[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                        end
                        else if (grp == GRP_NOTE_OFF)
                        begin
                            push = 1'b1;
                            kind = KIND_NOTE_OFF;
                        end
                        else if (grp == GRP_CONTROL)
                        begin
                            push = 1'b1;
                            kind = KIND_CONTROL;
                        end
                        else
                        begin
                            push = 1'b0;
                        end
                    end
                    // idle and the unused phase code drop stray data
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        op.is_pop  = (cmd == CMD_POP);
        op.push    = push;
        op.ev.kind = kind;
        op.ev.key  = first_reg;
        op.ev.vel  = byte_in[6:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            status_reg <= '0;
            first_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            first_reg  <= first_next;
        end
    end

endmodule

FILE: design/mcp_op_queue.sv
// short queue of classified words between the parser and the event engine
`timescale 1ns / 1ps

module mcp_op_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mcp_pkg::op_t  in_op,
    output logic          out_valid,
    input  logic          out_ready,
    output mcp_pkg::op_t  out_op
);
    import mcp_pkg::*;

    localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

    op_t                 slot_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != CNT_W'(OPQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_op    = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + OPQ_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + OPQ_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

FILE: design/mcp_back.sv
// event engine: ring buffer of note and control events and the result register
`timescale 1ns / 1ps

module mcp_back #(
    parameter int EVENT_SLOTS = mcp_pkg::EVENT_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    output logic                              op_ready,
    input  mcp_pkg::op_t                      op,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mcp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [mcp_pkg::OUT_USER_W-1:0]    m_tuser
);
    import mcp_pkg::*;

    localparam int IDX_W = $clog2(EVENT_SLOTS);

    event_t           mem [EVENT_SLOTS];
    event_t           rd_data_reg;
    logic [IDX_W-1:0] wr_idx_reg, rd_idx_reg;
    logic             out_valid_reg, hit_reg, waiting_reg;
    logic             waiting_next;
    logic             exec, empty, full, do_pop, do_push;
    logic [IDX_W-1:0] wr_adv, rd_adv;
    event_t           shown;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        begin
            r = (idx == IDX_W'(EVENT_SLOTS - 1)) ? '0 : idx + IDX_W'(1);
            return r;
        end
    endfunction

    assign op_ready = !out_valid_reg || m_tready;
    assign exec     = op_valid && op_ready;
    assign wr_adv   = advance(wr_idx_reg);
    assign rd_adv   = advance(rd_idx_reg);
    assign empty    = (rd_idx_reg == wr_idx_reg);
    // one slot stays free so full and empty differ
    assign full     = (wr_adv == rd_idx_reg);
    assign do_pop   = exec && op.is_pop && !empty;
    assign do_push  = exec && !op.is_pop && op.push && !full;

    always_comb
    begin
        if (op.is_pop)
        begin
            waiting_next = !empty && (rd_adv != wr_idx_reg);
        end
        else if (op.push && !full)
        begin
            waiting_next = 1'b1;
        end
        else
        begin
            waiting_next = !empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            waiting_reg   <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                out_valid_reg <= 1'b1;
                hit_reg       <= do_pop;
                waiting_reg   <= waiting_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_pop)
            begin
                rd_idx_reg <= rd_adv;
            end
            if (do_push)
            begin
                wr_idx_reg <= wr_adv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_idx_reg] <= op.ev;
        end
        if (do_pop)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign shown    = hit_reg ? rd_data_reg : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {shown.kind, hit_reg};
    assign m_tdata  = {1'b0, waiting_reg, shown.vel, shown.key};

`ifndef SYNTHESIS
    a_ring_not_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> (wr_idx_reg != rd_idx_reg))
        else $error("event ring write index ran onto read index");

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed word did not reach the result register");

    a_idle_indices_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> ($stable(wr_idx_reg) && $stable(rd_idx_reg)))
        else $error("ring indices moved without an executed word");

    a_hit_means_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && op.is_pop && empty) |=> !hit_reg)
        else $error("pop on empty ring returned an event");
`endif

endmodule

FILE: design/midi_channel_message_parser_fifo.sv
// top level of the midi channel message parser with event queue
//
//  port group   dir  tdata                                   tuser
//  s_*          in   byte_in[7:0]                            cmd[0]
//  m_*          out  key_or_controller[6:0],                 event_valid[0],
//                    velocity_or_value[13:7],                event_kind[2:1]
//                    events_waiting[14], zero[15]
//
// one word per cycle sustained while m_tready is high; a taken word is held in the op queue
// (parser classifies it there) until the engine executes it into the result register on m_*
// m_tready low holds the result register, then two op queue slots fill and s_tready drops
// reset clears parser state, ring indices and handshake state; ring contents are
// left unknown and are never read before they are written
`timescale 1ns / 1ps

module midi_channel_message_parser_fifo #(
    parameter int EVENT_SLOTS = mcp_pkg::EVENT_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mcp_pkg::IN_DATA_W-1:0]     s_tdata,   // byte_in[7:0]
    input  logic [mcp_pkg::IN_USER_W-1:0]     s_tuser,   // cmd[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mcp_pkg::OUT_DATA_W-1:0]    m_tdata,   // key[6:0] vel[13:7] waiting[14]
    output logic [mcp_pkg::OUT_USER_W-1:0]    m_tuser    // event_valid[0] event_kind[2:1]
);
    import mcp_pkg::*;

    logic f_valid, f_ready;
    op_t  f_op;
    logic q_valid, q_ready;
    op_t  q_op;

    mcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (s_tuser[0]),
        .byte_in  (s_tdata),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op       (f_op)
    );

    mcp_op_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_op     (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    mcp_back #(
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op_ready (q_ready),
        .op       (q_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: test/tb_midi_channel_message_parser_fifo.sv
// testbench for the midi channel message parser with event queue
`timescale 1ns / 1ps

module tb_midi_channel_message_parser_fifo;

    import mcp_pkg::*;

    localparam int SLOTS        = EVENT_SLOTS_DEF;
    localparam int RANDOM_WORDS = 1900;

    // status groups the package does not name
    localparam logic [3:0] GRP_POLY   = 4'hA;
    localparam logic [3:0] GRP_BEND   = 4'hE;
    localparam logic [3:0] GRP_SYSTEM = 4'hF;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } parse_phase_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [6:0] key;
        logic [6:0] vel;
        logic       waiting;
    } midi_report_t;

    typedef struct {
        logic         cmd;
        logic [7:0]   data;
        bit           typed;
        midi_report_t want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // byte_in[7:0]
    logic [IN_USER_W-1:0]  s_tuser;   // cmd[0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // key[6:0] vel[13:7] waiting[14] zero[15]
    logic [OUT_USER_W-1:0] m_tuser;   // event_valid[0] event_kind[2:1]

    // predictor state
    parse_phase_t phase_q;
    logic [7:0]   status_q;
    logic [6:0]   first_q;
    event_t       ring_q [SLOTS];
    int           wr_q;
    int           rd_q;

    midi_report_t awaited_reports [$];
    stim_row_t    directed_rows [$];

    bit tx_idle;
    bit rx_idle;
    int mismatches;
    int words_sent;
    int reports_seen;
    int queued_events;
    int full_drops;
    int valid_pops;
    int empty_pops;

    midi_channel_message_parser_fifo dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic midi_report_t midi_parse_step(logic cmd, logic [7:0] b);
        midi_report_t r;
        int           nxt;
        logic [1:0]   k;
        bit           keep;
        r = '0;
        k = KIND_NOTE_OFF;
        keep = 1'b1;
        if (cmd == CMD_BYTE)
        begin
            if (b[7])
            begin
                status_q = b;
                phase_q  = PH_FIRST;
            end
            else if (phase_q == PH_FIRST)
            begin
                first_q = b[6:0];
                phase_q = (status_q[7:4] == GRP_PROGRAM || status_q[7:4] == GRP_PRESSURE)
                          ? PH_IDLE : PH_SECOND;
            end
            else if (phase_q == PH_SECOND)
            begin
                phase_q = PH_IDLE;
                nxt = (wr_q + 1) % SLOTS;
                case (status_q[7:4])
                    GRP_NOTE_ON:  k = (b[6:0] == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                    GRP_NOTE_OFF: k = KIND_NOTE_OFF;
                    GRP_CONTROL:  k = KIND_CONTROL;
                    default:      keep = 1'b0;
                endcase
                if (keep)
                begin
                    if (nxt == rd_q)
                        full_drops++;
                    else
                    begin
                        ring_q[wr_q] = {k, first_q, b[6:0]};
                        wr_q = nxt;
                        queued_events++;
                    end
                end
            end
        end
        else if (rd_q != wr_q)
        begin
            r.valid = 1'b1;
            r.kind  = ring_q[rd_q].kind;
            r.key   = ring_q[rd_q].key;
            r.vel   = ring_q[rd_q].vel;
            rd_q    = (rd_q + 1) % SLOTS;
            valid_pops++;
        end
        else
            empty_pops++;
        r.waiting = (rd_q != wr_q);
        return r;
    endfunction

    task automatic add_row(input logic cmd, input logic [7:0] data, input bit typed,
                           input logic v, input logic [1:0] k, input logic [6:0] key,
                           input logic [6:0] vel, input logic w);
        stim_row_t row;
        row.cmd   = cmd;
        row.data  = data;
        row.typed = typed;
        row.want  = {v, k, key, vel, w};
        directed_rows.push_back(row);
    endtask

    // one input word: idle gap, handshake, then record what the block owes us
    task automatic send_word(input logic cmd, input logic [7:0] data, input bit typed,
                             input midi_report_t want);
        int           gap;
        midi_report_t predicted;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predicted = midi_parse_step(cmd, data);
        awaited_reports.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // sink side: random stalls, check every accepted word
    initial
    begin
        int           gap;
        midi_report_t want;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 14) : 0;
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            reports_seen++;
            if (awaited_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual tdata %0h tuser %0h",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = awaited_reports.pop_front();
                compare_field("event_valid", want.valid, m_tuser[0]);
                compare_field("event_kind", want.kind, m_tuser[2:1]);
                compare_field("key_or_controller", want.key, m_tdata[6:0]);
                compare_field("velocity_or_value", want.vel, m_tdata[13:7]);
                compare_field("events_waiting", want.waiting, m_tdata[14]);
                compare_field("tdata pad", 0, m_tdata[15]);
            end
        end
    end

    initial
    begin
        int          pick;
        int          n_data;
        int          pop_pct;
        int          next_shift;
        int          drain_cycles;
        logic [3:0]  grp;
        logic [3:0]  chan;
        logic [7:0]  dbyte;
        stim_row_t   row;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_BYTE;
        phase_q  = PH_IDLE;
        status_q = '0;
        first_q  = '0;
        wr_q     = 0;
        rd_q     = 0;
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        pop_pct  = 30;

        // directed table
        add_row(CMD_POP,  8'h00, 1, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // pop on empty
        add_row(CMD_BYTE, 8'h00, 1, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // data while idle
        add_row(CMD_BYTE, 8'h9F, 1, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h7F, 1, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h7F, 1, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 1);
        add_row(CMD_POP,  8'hFF, 1, 1, KIND_NOTE_ON,  7'h7F, 7'h7F, 0);
        add_row(CMD_BYTE, 8'h90, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // note on, vel 0
        add_row(CMD_BYTE, 8'h00, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h00, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h80, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // note off
        add_row(CMD_BYTE, 8'h3C, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h40, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'hB5, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // control change
        add_row(CMD_BYTE, 8'h07, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h64, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'hC3, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // program change
        add_row(CMD_BYTE, 8'h05, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h10, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'hD0, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // channel pressure
        add_row(CMD_BYTE, 8'h20, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'hF8, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // real-time status
        add_row(CMD_BYTE, 8'h01, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'hE0, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0); // restart, pitch bend
        add_row(CMD_BYTE, 8'h11, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);
        add_row(CMD_BYTE, 8'h22, 0, 0, KIND_NOTE_OFF, 7'h00, 7'h00, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_word(row.cmd, row.data, row.typed, row.want);
        end

        next_shift = 0;
        while (words_sent < directed_rows.size() + RANDOM_WORDS)
        begin
            if (words_sent >= next_shift)
            begin
                // let everything drain, then pick new pacing and pop mix
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (awaited_reports.size() != 0) @(posedge clk);
                next_shift = words_sent + $urandom_range(60, 200);
                tx_idle = ($urandom_range(0, 2) != 0);
                rx_idle = ($urandom_range(0, 2) != 0);
                case ($urandom_range(0, 3))
                    0:       pop_pct = 5;
                    1:       pop_pct = 30;
                    2:       pop_pct = 50;
                    default: pop_pct = 80;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < pop_pct)
                send_word(CMD_POP, $urandom_range(0, 255), 0, '0);
            else if (pick < pop_pct + 8)
                send_word(CMD_BYTE, $urandom_range(0, 255), 0, '0);
            else
            begin
                pick = $urandom_range(0, 99);
                grp = (pick < 30) ? GRP_NOTE_ON  :
                      (pick < 45) ? GRP_NOTE_OFF :
                      (pick < 65) ? GRP_CONTROL  :
                      (pick < 73) ? GRP_PROGRAM  :
                      (pick < 80) ? GRP_PRESSURE :
                      (pick < 87) ? GRP_POLY     :
                      (pick < 93) ? GRP_BEND     : GRP_SYSTEM;
                n_data = (grp == GRP_PROGRAM || grp == GRP_PRESSURE) ? 1 : 2;
                // truncated message, the next status cuts it off
                if ($urandom_range(0, 9) == 0)
                    n_data = $urandom_range(0, n_data - 1);
                chan = $urandom_range(0, 15);
                send_word(CMD_BYTE, {grp, chan}, 0, '0);
                for (int i = 0; i < n_data; i++)
                begin
                    if ($urandom_range(0, 99) < pop_pct / 3)
                        send_word(CMD_POP, $urandom_range(0, 255), 0, '0);
                    if ($urandom_range(0, 9) == 0)
                        dbyte = $urandom_range(0, 1) ? 8'h7F : 8'h00;
                    else
                        dbyte = $urandom_range(0, 127);
                    if (grp == GRP_NOTE_ON && i == 1 && $urandom_range(0, 4) == 0)
                        dbyte = 8'h00;
                    send_word(CMD_BYTE, dbyte, 0, '0);
                end
            end
        end
        s_tvalid <= 1'b0;

        drain_cycles = 0;
        while (awaited_reports.size() != 0 && drain_cycles < 2000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (20) @(posedge clk);
        if (awaited_reports.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d words never arrived, expected 0 left, actual %0d",
                     $time, awaited_reports.size(), awaited_reports.size());
        end

        $display("%0d words in (%0d table rows), %0d words out; %0d events queued, %0d lost to a full queue",
                 words_sent, directed_rows.size(), reports_seen, queued_events, full_drops);
        $display("%0d pops returned an event, %0d pops found the queue empty; %0d mismatches",
                 valid_pops, empty_pops, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
